>>> src/trme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_pkg
// Shared types and constants of the toy register/memory executor.
// ----------------------------------------------------------------------------
package trme_pkg;

    localparam int WORD_W = 16;
    localparam int PC_W   = 10;
    localparam int IDX_W  = 10;

    // command field
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EXEC = 1'b1;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_INC   = 4'd2,
        OP_DEC   = 4'd3,
        OP_PRINT = 4'd4,
        OP_JNZ   = 4'd5,
        OP_JZ    = 4'd6,
        OP_END   = 4'd7,
        OP_JMP   = 4'd8,
        OP_MOV   = 4'd9
    } op_t;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PC_W-1:0]   pc_t;

endpackage

>>> src/trme_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trme_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module trme_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1030,
    parameter int ADDR_W = 11
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> src/toy_register_memory_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toy_register_memory_executor
// Executes one decoded instruction (or appends one data word) per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall   | cmd opcode dst_index src_index
//          |           |                    | dst_is_reg src_is_reg load_value
//  out     | output    | out_valid/out_stall | next_pc halted print_valid
//          |           |                    | print_value last_result
//
//  One item per cycle sustained while out_stall is low. Stage 0 issues both
//  operand reads to the shared RAM (data words plus registers), stage 1
//  computes and writes back, then the result register. Each result is held
//  in the result register until it transfers out. A one-entry bypass of the
//  last write covers back-to-back hazards.
//  Reset clears pc, recent value, load pointer and the register valid bits;
//  no clearing pass. An out_stall on a valid result holds a full stage 1 and raises in_stall.
// ----------------------------------------------------------------------------
module toy_register_memory_executor #(
    parameter int MEM_WORDS = 1024,
    parameter int NUM_REGS  = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [3:0]                     opcode,
    input  logic [trme_pkg::IDX_W-1:0]     dst_index,
    input  logic [trme_pkg::IDX_W-1:0]     src_index,
    input  logic                           dst_is_reg,
    input  logic                           src_is_reg,
    input  logic [trme_pkg::WORD_W-1:0]    load_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trme_pkg::PC_W-1:0]      next_pc,
    output logic                           halted,
    output logic                           print_valid,
    output logic [trme_pkg::WORD_W-1:0]    print_value,
    output logic [trme_pkg::WORD_W-1:0]    last_result
);

    localparam int DEPTH = MEM_WORDS + NUM_REGS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LP_W  = $clog2(MEM_WORDS + 1);
    localparam int RI_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // ---------------- handshake ----------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic s1_fire;
    logic in_acc;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_acc   = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && s1_adv;

    // ---------------- architectural state ----------------
    trme_pkg::pc_t   pc_reg;
    trme_pkg::word_t recent_reg;
    logic [LP_W-1:0] lp_reg;
    logic [NUM_REGS-1:0] rf_valid_reg;

    // ---------------- stage 0: operand addressing ----------------
    logic          dst_mem_ok, dst_reg_ok, src_mem_ok, src_reg_ok;
    logic          dst_ok, src_ok, dst_unw, src_unw;
    logic [RI_W-1:0] dst_ridx, src_ridx;
    logic [AW-1:0] dst_addr, src_addr;

    always_comb
    begin
        dst_mem_ok = 32'(dst_index) < MEM_WORDS;
        dst_reg_ok = 32'(dst_index) < NUM_REGS;
        src_mem_ok = 32'(src_index) < MEM_WORDS;
        src_reg_ok = 32'(src_index) < NUM_REGS;
        dst_ok     = dst_is_reg ? dst_reg_ok : dst_mem_ok;
        src_ok     = src_is_reg ? src_reg_ok : src_mem_ok;
        dst_ridx   = dst_index[RI_W-1:0];
        src_ridx   = src_index[RI_W-1:0];
        // registers never written read as zero
        dst_unw    = dst_is_reg && dst_reg_ok && !rf_valid_reg[dst_ridx];
        src_unw    = src_is_reg && src_reg_ok && !rf_valid_reg[src_ridx];
        dst_addr   = dst_is_reg ? AW'(32'(MEM_WORDS) + 32'(dst_index)) : AW'(dst_index);
        src_addr   = src_is_reg ? AW'(32'(MEM_WORDS) + 32'(src_index)) : AW'(src_index);
    end

    // ---------------- stage 1 registers ----------------
    logic                          s1_cmd_reg;
    trme_pkg::op_t                 s1_op_reg;
    logic [trme_pkg::IDX_W-1:0]    s1_dst_index_reg;
    logic [AW-1:0]                 s1_dst_addr_reg, s1_src_addr_reg;
    logic                          s1_dst_ok_reg, s1_src_ok_reg;
    logic                          s1_dst_unw_reg, s1_src_unw_reg;
    logic                          s1_dst_is_reg_reg;
    logic [RI_W-1:0]               s1_dst_ridx_reg;
    trme_pkg::word_t               s1_load_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg        <= cmd;
            s1_op_reg         <= trme_pkg::op_t'(opcode);
            s1_dst_index_reg  <= dst_index;
            s1_dst_addr_reg   <= dst_addr;
            s1_src_addr_reg   <= src_addr;
            s1_dst_ok_reg     <= dst_ok;
            s1_src_ok_reg     <= src_ok;
            s1_dst_unw_reg    <= dst_unw;
            s1_src_unw_reg    <= src_unw;
            s1_dst_is_reg_reg <= dst_is_reg;
            s1_dst_ridx_reg   <= dst_ridx;
            s1_load_value_reg <= load_value;
        end
    end

    // ---------------- storage ----------------
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    trme_pkg::word_t mem_wdata;
    trme_pkg::word_t rdata_a, rdata_b;

    trme_ram #(
        .WIDTH  (trme_pkg::WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (in_acc),
        .raddr_a (dst_addr),
        .raddr_b (src_addr),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // last write, for the item whose read shared its edge
    logic            last_wr_valid_reg;
    logic [AW-1:0]   last_wr_addr_reg;
    trme_pkg::word_t last_wr_data_reg;

    // ---------------- stage 1: execute ----------------
    trme_pkg::word_t dv, sv, res;
    logic            is_arith, is_wr, is_exec;
    logic            res_halted, res_print;
    trme_pkg::pc_t   pc_inc, pc_next;
    trme_pkg::word_t recent_next;
    logic            load_ok;

    always_comb
    begin
        if (!s1_dst_ok_reg)
            dv = '0;
        else if (last_wr_valid_reg && last_wr_addr_reg == s1_dst_addr_reg)
            dv = last_wr_data_reg;
        else if (s1_dst_unw_reg)
            dv = '0;
        else
            dv = rdata_a;

        if (!s1_src_ok_reg)
            sv = '0;
        else if (last_wr_valid_reg && last_wr_addr_reg == s1_src_addr_reg)
            sv = last_wr_data_reg;
        else if (s1_src_unw_reg)
            sv = '0;
        else
            sv = rdata_b;

        is_exec    = (s1_cmd_reg == trme_pkg::CMD_EXEC);
        pc_inc     = pc_reg + trme_pkg::pc_t'(1);
        res        = '0;
        is_arith   = 1'b0;
        is_wr      = 1'b0;
        res_print  = 1'b0;
        res_halted = 1'b0;
        pc_next    = pc_inc;

        unique case (s1_op_reg)
            trme_pkg::OP_ADD:
            begin
                res = dv + sv;  is_arith = 1'b1;  is_wr = 1'b1;
            end
            trme_pkg::OP_SUB:
            begin
                res = dv - sv;  is_arith = 1'b1;  is_wr = 1'b1;
            end
            trme_pkg::OP_INC:
            begin
                res = dv + trme_pkg::word_t'(1);  is_arith = 1'b1;  is_wr = 1'b1;
            end
            trme_pkg::OP_DEC:
            begin
                res = dv - trme_pkg::word_t'(1);  is_arith = 1'b1;  is_wr = 1'b1;
            end
            trme_pkg::OP_MOV:
            begin
                res = sv;  is_wr = 1'b1;
            end
            trme_pkg::OP_PRINT:
            begin
                res_print = 1'b1;
            end
            trme_pkg::OP_JNZ:
            begin
                if (recent_reg != '0)
                    pc_next = s1_dst_index_reg;
            end
            trme_pkg::OP_JZ:
            begin
                if (recent_reg == '0)
                    pc_next = s1_dst_index_reg;
            end
            trme_pkg::OP_JMP:
            begin
                pc_next = s1_dst_index_reg;
            end
            default:
            begin
                // end and unknown opcodes
                res_halted = 1'b1;
                pc_next    = pc_reg;
            end
        endcase

        if (!is_exec)
        begin
            is_arith   = 1'b0;
            is_wr      = 1'b0;
            res_print  = 1'b0;
            res_halted = 1'b0;
            pc_next    = pc_reg;
        end

        recent_next = is_arith ? res : recent_reg;
        load_ok     = !is_exec && (lp_reg < LP_W'(MEM_WORDS));

        mem_we    = 1'b0;
        mem_waddr = s1_dst_addr_reg;
        mem_wdata = res;
        if (s1_fire)
        begin
            if (load_ok)
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(lp_reg);
                mem_wdata = s1_load_value_reg;
            end
            else if (is_wr && s1_dst_ok_reg)
            begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg            <= '0;
            recent_reg        <= '0;
            lp_reg            <= '0;
            rf_valid_reg      <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                pc_reg     <= pc_next;
                recent_reg <= recent_next;
                if (load_ok)
                    lp_reg <= lp_reg + LP_W'(1);
            end
            if (mem_we)
            begin
                last_wr_valid_reg <= 1'b1;
                if (is_exec && s1_dst_is_reg_reg)
                    rf_valid_reg[s1_dst_ridx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            last_wr_addr_reg <= mem_waddr;
            last_wr_data_reg <= mem_wdata;
        end
    end

    // ---------------- result register ----------------
    trme_pkg::pc_t   next_pc_reg;
    logic            halted_reg;
    logic            print_valid_reg;
    trme_pkg::word_t print_value_reg;
    trme_pkg::word_t last_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            next_pc_reg     <= pc_next;
            halted_reg      <= res_halted;
            print_valid_reg <= res_print;
            print_value_reg <= res_print ? dv : '0;
            last_result_reg <= recent_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign halted      = halted_reg;
    assign print_valid = print_valid_reg;
    assign print_value = print_value_reg;
    assign last_result = last_result_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("in_stall raised with a free slot");

    a_load_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lp_reg) <= MEM_WORDS)
        else $error("load pointer beyond memory");

    a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res_halted) |=> (pc_reg == $past(pc_reg)))
        else $error("pc moved on halt");

    a_halt_no_print: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && res_halted) |-> !res_print && !mem_we)
        else $error("halt with side effect");
`endif

endmodule

>>> sim/tb_toy_register_memory_executor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toy_register_memory_executor
// Self-checking bench for the toy register/memory executor. A short table of
// directed items runs first, followed by two random instruction streams, one
// rich in loads and one mostly instructions. Every transfer in is run through
// a local model of the machine, and every transfer out is compared field by
// field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb_toy_register_memory_executor;

    localparam int MEM_WORDS = 1024;
    localparam int NUM_REGS  = 6;
    localparam int DIR_ROWS  = 25;
    localparam int MIX_ITEMS = 200;
    localparam int RUN_ITEMS = 220;

    localparam logic [3:0] OP_HALT_LO = 4'd10;
    localparam logic [3:0] OP_HALT_HI = 4'd15;
    localparam logic       IS_REG     = 1'b1;
    localparam logic       IS_MEM     = 1'b0;

    typedef struct packed {
        logic                         cmd;
        logic [3:0]                   opcode;
        logic [trme_pkg::IDX_W-1:0]   dst_index;
        logic [trme_pkg::IDX_W-1:0]   src_index;
        logic                         dst_is_reg;
        logic                         src_is_reg;
        trme_pkg::word_t              load_value;
    } instr_t;

    typedef struct packed {
        trme_pkg::pc_t   next_pc;
        logic            halted;
        logic            print_valid;
        trme_pkg::word_t print_value;
        trme_pkg::word_t last_result;
    } result_t;

    typedef struct {
        instr_t  it;
        bit      fixed;
        result_t res;
    } row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic [3:0]                 opcode;
    logic [trme_pkg::IDX_W-1:0] dst_index;
    logic [trme_pkg::IDX_W-1:0] src_index;
    logic                       dst_is_reg;
    logic                       src_is_reg;
    trme_pkg::word_t            load_value;
    logic                       out_valid;
    logic                       out_stall;
    trme_pkg::pc_t              next_pc;
    logic                       halted;
    logic                       print_valid;
    trme_pkg::word_t            print_value;
    trme_pkg::word_t            last_result;

    // machine state as the checker sees it
    trme_pkg::word_t regs_q [NUM_REGS];
    trme_pkg::word_t mem_q  [MEM_WORDS];
    bit              mem_ok [MEM_WORDS];
    trme_pkg::pc_t   pc_q;
    trme_pkg::word_t recent_q;
    int              ld_ptr;

    result_t expected_q [$];
    int      fails;
    int      burst_left;
    int      stall_cyc;
    bit      cur_fixed;
    result_t cur_fixed_res;
    row_t    dir_tab [DIR_ROWS];

    toy_register_memory_executor #(
        .MEM_WORDS (MEM_WORDS),
        .NUM_REGS  (NUM_REGS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .opcode      (opcode),
        .dst_index   (dst_index),
        .src_index   (src_index),
        .dst_is_reg  (dst_is_reg),
        .src_is_reg  (src_is_reg),
        .load_value  (load_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .next_pc     (next_pc),
        .halted      (halted),
        .print_valid (print_valid),
        .print_value (print_value),
        .last_result (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic trme_pkg::word_t read_opnd(input logic [trme_pkg::IDX_W-1:0] idx,
                                                  input logic is_reg);
        if (is_reg)
            return (idx < NUM_REGS) ? regs_q[idx] : '0;
        return mem_q[idx];
    endfunction

    function automatic void write_opnd(input logic [trme_pkg::IDX_W-1:0] idx,
                                       input logic is_reg, input trme_pkg::word_t v);
        if (is_reg)
        begin
            if (idx < NUM_REGS)
                regs_q[idx] = v;
        end
        else
        begin
            mem_q[idx]  = v;
            mem_ok[idx] = 1'b1;
        end
    endfunction

    // advance the machine by one item and return what it should report
    function automatic result_t execute_item(input instr_t it);
        result_t         r;
        trme_pkg::word_t dv;
        trme_pkg::word_t sv;
        trme_pkg::word_t v;
        trme_pkg::pc_t   nxt;
        r   = '0;
        nxt = pc_q + trme_pkg::pc_t'(1);
        if (it.cmd == trme_pkg::CMD_LOAD)
        begin
            if (ld_ptr < MEM_WORDS)
            begin
                mem_q[ld_ptr]  = it.load_value;
                mem_ok[ld_ptr] = 1'b1;
                ld_ptr++;
            end
            nxt = pc_q;
        end
        else
        begin
            dv = read_opnd(it.dst_index, it.dst_is_reg);
            sv = read_opnd(it.src_index, it.src_is_reg);
            unique case (it.opcode)
                trme_pkg::OP_ADD, trme_pkg::OP_SUB, trme_pkg::OP_INC, trme_pkg::OP_DEC:
                begin
                    unique case (it.opcode)
                        trme_pkg::OP_ADD: v = dv + sv;
                        trme_pkg::OP_SUB: v = dv - sv;
                        trme_pkg::OP_INC: v = dv + trme_pkg::word_t'(1);
                        default:          v = dv - trme_pkg::word_t'(1);
                    endcase
                    write_opnd(it.dst_index, it.dst_is_reg, v);
                    recent_q = v;
                end
                trme_pkg::OP_PRINT:
                begin
                    r.print_valid = 1'b1;
                    r.print_value = dv;
                end
                trme_pkg::OP_JNZ: if (recent_q != '0) nxt = it.dst_index;
                trme_pkg::OP_JZ:  if (recent_q == '0) nxt = it.dst_index;
                trme_pkg::OP_JMP: nxt = it.dst_index;
                trme_pkg::OP_MOV: write_opnd(it.dst_index, it.dst_is_reg, sv);
                default:
                begin
                    // end and unknown opcodes: flag and hold pc
                    r.halted = 1'b1;
                    nxt      = pc_q;
                end
            endcase
        end
        pc_q          = nxt;
        r.next_pc     = pc_q;
        r.last_result = recent_q;
        return r;
    endfunction

    function automatic instr_t exec_item(input logic [3:0] op, input int dst, input logic dreg,
                                         input int src, input logic sreg);
        instr_t it;
        it            = '0;
        it.cmd        = trme_pkg::CMD_EXEC;
        it.opcode     = op;
        it.dst_index  = trme_pkg::IDX_W'(dst);
        it.dst_is_reg = dreg;
        it.src_index  = trme_pkg::IDX_W'(src);
        it.src_is_reg = sreg;
        return it;
    endfunction

    function automatic instr_t load_item(input trme_pkg::word_t v);
        instr_t it;
        it            = '0;
        it.cmd        = trme_pkg::CMD_LOAD;
        it.load_value = v;
        return it;
    endfunction

    function automatic result_t pack_res(input int pc, input logic h, input logic pv,
                                         input trme_pkg::word_t pval,
                                         input trme_pkg::word_t last);
        result_t r;
        r.next_pc     = trme_pkg::PC_W'(pc);
        r.halted      = h;
        r.print_valid = pv;
        r.print_value = pval;
        r.last_result = last;
        return r;
    endfunction

    // pick a memory word that already holds data, else fall back to a register
    function automatic void pick_written(inout logic [trme_pkg::IDX_W-1:0] idx,
                                         inout logic is_reg);
        if (is_reg || mem_ok[idx])
            return;
        if (ld_ptr > 0)
            idx = trme_pkg::IDX_W'($urandom_range(0, ld_ptr - 1));
        else
        begin
            is_reg = IS_REG;
            idx    = trme_pkg::IDX_W'($urandom_range(0, NUM_REGS - 1));
        end
    endfunction

    function automatic instr_t random_item(input int load_pct);
        instr_t it;
        it.cmd        = ($urandom_range(0, 99) < load_pct) ? trme_pkg::CMD_LOAD
                                                           : trme_pkg::CMD_EXEC;
        it.opcode     = ($urandom_range(0, 99) < 6)
                        ? 4'($urandom_range(OP_HALT_LO, OP_HALT_HI))
                        : 4'($urandom_range(trme_pkg::OP_ADD, trme_pkg::OP_MOV));
        it.dst_index  = trme_pkg::IDX_W'($urandom);
        it.src_index  = trme_pkg::IDX_W'($urandom);
        it.dst_is_reg = 1'($urandom);
        it.src_is_reg = 1'($urandom);
        it.load_value = trme_pkg::WORD_W'($urandom);
        if (it.cmd == trme_pkg::CMD_LOAD)
            return it;
        // mostly live registers; low memory words often, to provoke hazards
        if (it.dst_is_reg && $urandom_range(0, 7) != 0)
            it.dst_index = trme_pkg::IDX_W'($urandom_range(0, NUM_REGS - 1));
        if (it.src_is_reg && $urandom_range(0, 7) != 0)
            it.src_index = trme_pkg::IDX_W'($urandom_range(0, NUM_REGS - 1));
        if (!it.dst_is_reg && $urandom_range(0, 1) == 0)
            it.dst_index = trme_pkg::IDX_W'($urandom_range(0, 7));
        if (!it.src_is_reg && $urandom_range(0, 1) == 0)
            it.src_index = trme_pkg::IDX_W'($urandom_range(0, 7));
        if (it.opcode inside {trme_pkg::OP_ADD, trme_pkg::OP_SUB, trme_pkg::OP_INC,
                              trme_pkg::OP_DEC, trme_pkg::OP_PRINT})
            pick_written(it.dst_index, it.dst_is_reg);
        // operand minus itself gives the zero tests something to see
        if (it.opcode == trme_pkg::OP_SUB && $urandom_range(0, 3) == 0)
        begin
            it.src_index  = it.dst_index;
            it.src_is_reg = it.dst_is_reg;
        end
        if (it.opcode inside {trme_pkg::OP_ADD, trme_pkg::OP_SUB, trme_pkg::OP_MOV})
            pick_written(it.src_index, it.src_is_reg);
        return it;
    endfunction

    // entered and left at a falling edge; returns once the transfer is taken
    task automatic put_item(input instr_t it, input bit fixed, input result_t fres);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cur_fixed     = fixed;
        cur_fixed_res = fres;
        cmd        <= it.cmd;
        opcode     <= it.opcode;
        dst_index  <= it.dst_index;
        src_index  <= it.src_index;
        dst_is_reg <= it.dst_is_reg;
        src_is_reg <= it.src_is_reg;
        load_value <= it.load_value;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver back-pressure: rotating phases of none, light, heavy and periodic
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_cyc++;
            unique case (stall_cyc[8:7])
                2'd0:    out_stall <= 1'b0;
                2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
                2'd2:    out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= (stall_cyc[2:0] < 3'd5);
            endcase
        end
    end

    always @(posedge clk)
    begin : take_input
        result_t predicted;
        if (rst_n && in_valid && !in_stall)
        begin
            predicted = execute_item({cmd, opcode, dst_index, src_index,
                                      dst_is_reg, src_is_reg, load_value});
            expected_q.insert(expected_q.size(), cur_fixed ? cur_fixed_res : predicted);
        end
    end

    always @(posedge clk)
    begin : check_output
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: next_pc %0d", next_pc);
                fails++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (next_pc !== e.next_pc)
                begin
                    $error("next_pc: expected %0d, got %0d", e.next_pc, next_pc);
                    fails++;
                end
                if (halted !== e.halted)
                begin
                    $error("halted: expected %0d, got %0d", e.halted, halted);
                    fails++;
                end
                if (print_valid !== e.print_valid)
                begin
                    $error("print_valid: expected %0d, got %0d", e.print_valid, print_valid);
                    fails++;
                end
                if (print_value !== e.print_value)
                begin
                    $error("print_value: expected %h, got %h", e.print_value, print_value);
                    fails++;
                end
                if (last_result !== e.last_result)
                begin
                    $error("last_result: expected %h, got %h", e.last_result, last_result);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        int n;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        cmd        = trme_pkg::CMD_LOAD;
        opcode     = '0;
        dst_index  = '0;
        src_index  = '0;
        dst_is_reg = 1'b0;
        src_is_reg = 1'b0;
        load_value = '0;
        fails      = 0;
        burst_left = 0;
        stall_cyc  = 0;
        cur_fixed  = 1'b0;
        cur_fixed_res = '0;
        pc_q       = '0;
        recent_q   = '0;
        ld_ptr     = 0;
        foreach (regs_q[i])
            regs_q[i] = '0;
        foreach (mem_q[i])
        begin
            mem_q[i]  = '0;
            mem_ok[i] = 1'b0;
        end

        dir_tab = '{
            '{exec_item(trme_pkg::OP_PRINT, 0, IS_REG, 0, IS_REG), 1'b1,
              pack_res(1, 0, 1, 0, 0)},
            '{load_item(16'hFFFF),                          1'b1, pack_res(1, 0, 0, 0, 0)},
            '{load_item(16'h0000),                          1'b1, pack_res(1, 0, 0, 0, 0)},
            '{load_item(16'h8001),                          1'b1, pack_res(1, 0, 0, 0, 0)},
            '{exec_item(trme_pkg::OP_INC, 0, IS_REG, 0, IS_REG), 1'b1,
              pack_res(2, 0, 0, 0, 1)},
            '{exec_item(trme_pkg::OP_DEC, 1, IS_REG, 0, IS_REG), 1'b1,
              pack_res(3, 0, 0, 0, 16'hFFFF)},
            '{exec_item(trme_pkg::OP_ADD, 1, IS_REG, 0, IS_MEM), 1'b0, '0},
            '{exec_item(trme_pkg::OP_SUB, 0, IS_REG, 1, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_MOV, 1, IS_MEM, 1, IS_REG), 1'b0, '0},
            // memory word wraps to zero, so the jz below is taken
            '{exec_item(trme_pkg::OP_INC, 0, IS_MEM, 0, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_JZ, 1023, IS_REG, 0, IS_REG), 1'b1,
              pack_res(1023, 0, 0, 0, 0)},
            '{exec_item(trme_pkg::OP_PRINT, 5, IS_REG, 0, IS_REG), 1'b1,
              pack_res(0, 0, 1, 0, 0)},
            '{exec_item(trme_pkg::OP_JNZ, 500, IS_REG, 0, IS_REG), 1'b1,
              pack_res(1, 0, 0, 0, 0)},
            '{exec_item(trme_pkg::OP_DEC, 1, IS_MEM, 0, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_JNZ, 10'h2AA, IS_REG, 0, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_END, 0, IS_REG, 0, IS_REG), 1'b0, '0},
            '{exec_item(OP_HALT_HI, 1023, IS_REG, 1023, IS_REG), 1'b0, '0},
            '{exec_item(OP_HALT_LO, 0, IS_REG, 0, IS_REG),  1'b0, '0},
            '{exec_item(trme_pkg::OP_JMP, 0, IS_REG, 0, IS_REG), 1'b0, '0},
            // write to a register that does not exist is dropped
            '{exec_item(trme_pkg::OP_MOV, 6, IS_REG, 0, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_ADD, 0, IS_REG, 1023, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_PRINT, 2, IS_MEM, 0, IS_REG), 1'b0, '0},
            '{exec_item(trme_pkg::OP_SUB, 2, IS_MEM, 2, IS_MEM), 1'b0, '0},
            '{exec_item(trme_pkg::OP_PRINT, 1023, IS_REG, 0, IS_REG), 1'b0, '0},
            '{{trme_pkg::CMD_LOAD, OP_HALT_HI, 10'h3FF, 10'h3FF, 1'b1, 1'b1, 16'hFFFF},
              1'b0, '0}
        };

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            put_item(dir_tab[i].it, dir_tab[i].fixed, dir_tab[i].res);

        for (n = 0; n < MIX_ITEMS; n++)
            put_item(random_item(30), 1'b0, '0);

        // long instruction run with the odd load mixed in
        n = 0;
        while (n < RUN_ITEMS)
        begin
            instr_t it;
            it = random_item(5);
            if (it.cmd == trme_pkg::CMD_EXEC)
                n++;
            put_item(it, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
src/trme_pkg.sv
src/trme_ram.sv
src/toy_register_memory_executor.sv
sim/tb_toy_register_memory_executor.sv
